/* sv/spq_pkg.sv */
package spq_pkg;

    // Operation codes carried by the op field
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_SERVED   = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic enq;   // insert the new entry at its sorted place
        logic deq;   // shift the row one place towards the front
    } t_cell_ctl;

endpackage

/* sv/spq_cell.sv */
module spq_cell #(
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic                  i_occupied,
    input  logic [PRIO_BITS-1:0]  i_new_prio,
    input  logic [TAG_BITS-1:0]   i_new_tag,
    input  logic                  i_left_ge,
    input  logic [PRIO_BITS-1:0]  i_left_prio,
    input  logic [TAG_BITS-1:0]   i_left_tag,
    input  logic [PRIO_BITS-1:0]  i_right_prio,
    input  logic [TAG_BITS-1:0]   i_right_tag,
    output logic [PRIO_BITS-1:0]  o_prio,
    output logic [TAG_BITS-1:0]   o_tag,
    output logic                  o_ge
);

    logic [PRIO_BITS-1:0] r_prio;
    logic [TAG_BITS-1:0]  r_tag;
    logic [PRIO_BITS-1:0] n_prio;
    logic [TAG_BITS-1:0]  n_tag;

    // Held entry stays ahead of the new one when its priority is not lower
    assign o_ge   = i_occupied && (r_prio >= i_new_prio);
    assign o_prio = r_prio;
    assign o_tag  = r_tag;

    always_comb begin
        n_prio = r_prio;
        n_tag  = r_tag;
        if (i_ctl.enq && !o_ge) begin
            if (i_left_ge) begin
                n_prio = i_new_prio;
                n_tag  = i_new_tag;
            end else begin
                n_prio = i_left_prio;
                n_tag  = i_left_tag;
            end
        end else if (i_ctl.deq) begin
            n_prio = i_right_prio;
            n_tag  = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio <= n_prio;
        r_tag  <= n_tag;
    end

endmodule

/* sv/stable_priority_queue.sv */
// Channel  Valid         Stall         Payload
// input    i_in_valid    o_in_stall    i_op, i_priority_req, i_tag
// output   o_out_valid   i_out_stall   o_status, o_served_tag, o_served_priority,
//                                      o_occupancy
//
// The row of DEPTH cells shifts or inserts in the cycle of acceptance, and the result
// is held in a single output register. An item is taken in every cycle unless the
// output register holds a result that is stalled. Reset empties the queue at once;
// cell contents are not cleared.
module stable_priority_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [PRIO_BITS-1:0]          i_priority_req,
    input  logic [TAG_BITS-1:0]           i_tag,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic [TAG_BITS-1:0]           o_served_tag,
    output logic [PRIO_BITS-1:0]          o_served_priority,
    output logic [$clog2(DEPTH+1)-1:0]    o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                  accept;
    logic                  is_full;
    logic                  is_empty;
    spq_pkg::t_cell_ctl    ctl;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    spq_pkg::t_status      r_status;
    spq_pkg::t_status      n_status;
    logic [TAG_BITS-1:0]   r_served_tag;
    logic [TAG_BITS-1:0]   n_served_tag;
    logic [PRIO_BITS-1:0]  r_served_prio;
    logic [PRIO_BITS-1:0]  n_served_prio;

    logic [PRIO_BITS-1:0]  cell_prio [DEPTH];
    logic [TAG_BITS-1:0]   cell_tag  [DEPTH];
    logic                  cell_ge   [DEPTH];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign is_full    = (r_count == FULL_CNT);
    assign is_empty   = (r_count == '0);

    assign ctl.enq = accept && (i_op == spq_pkg::OP_ENQ) && !is_full;
    assign ctl.deq = accept && (i_op == spq_pkg::OP_DEQ) && !is_empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                  left_ge;
        logic [PRIO_BITS-1:0]  left_prio;
        logic [TAG_BITS-1:0]   left_tag;
        logic [PRIO_BITS-1:0]  right_prio;
        logic [TAG_BITS-1:0]   right_tag;

        if (g == 0) begin : g_head
            assign left_ge   = 1'b1;
            assign left_prio = i_priority_req;
            assign left_tag  = i_tag;
        end else begin : g_body
            assign left_ge   = cell_ge[g-1];
            assign left_prio = cell_prio[g-1];
            assign left_tag  = cell_tag[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_prio = cell_prio[g];
            assign right_tag  = cell_tag[g];
        end else begin : g_inner
            assign right_prio = cell_prio[g+1];
            assign right_tag  = cell_tag[g+1];
        end

        spq_cell #(
            .PRIO_BITS (PRIO_BITS),
            .TAG_BITS  (TAG_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (CNT_W'(g) < r_count),
            .i_new_prio   (i_priority_req),
            .i_new_tag    (i_tag),
            .i_left_ge    (left_ge),
            .i_left_prio  (left_prio),
            .i_left_tag   (left_tag),
            .i_right_prio (right_prio),
            .i_right_tag  (right_tag),
            .o_prio       (cell_prio[g]),
            .o_tag        (cell_tag[g]),
            .o_ge         (cell_ge[g])
        );
    end

    always_comb begin
        n_count       = r_count;
        n_served_tag  = '0;
        n_served_prio = '0;
        if (i_op == spq_pkg::OP_ENQ) begin
            if (is_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_status = spq_pkg::ST_ENQUEUED;
                n_count  = r_count + CNT_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_status      = spq_pkg::ST_SERVED;
                n_served_tag  = cell_tag[0];
                n_served_prio = cell_prio[0];
                n_count       = r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_status      <= n_status;
            r_served_tag  <= n_served_tag;
            r_served_prio <= n_served_prio;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_served_tag      = r_served_tag;
    assign o_served_priority = r_served_prio;
    assign o_occupancy       = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("occupancy beyond depth");

    a_empty_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == spq_pkg::OP_DEQ) && is_empty
        |=> (o_status == spq_pkg::ST_EMPTY) && (r_count == '0))
        else $error("dequeue from empty not reported");

    a_serve_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == spq_pkg::OP_DEQ) && !is_empty
        |=> (r_count == $past(r_count) - CNT_W'(1)) && (o_status == spq_pkg::ST_SERVED))
        else $error("served item did not shrink the queue");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_op == spq_pkg::OP_ENQ) && is_full
        |=> (r_count == FULL_CNT) && (o_status == spq_pkg::ST_FULL))
        else $error("enqueue into full queue not dropped");

endmodule

/* dv/spq_checker.sv */
`timescale 1ns / 100ps

module spq_checker #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int TAG_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_op,
    input  logic [PRIO_BITS-1:0]       i_priority_req,
    input  logic [TAG_BITS-1:0]        i_tag,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [1:0]                 i_status,
    input  logic [TAG_BITS-1:0]        i_served_tag,
    input  logic [PRIO_BITS-1:0]       i_served_priority,
    input  logic [$clog2(DEPTH+1)-1:0] i_occupancy,
    output int                         o_mismatches,
    output int                         o_awaited
);

    localparam int OCC_BITS = $clog2(DEPTH + 1);

    typedef struct {
        spq_pkg::t_status     status;
        logic [TAG_BITS-1:0]  tag;
        logic [PRIO_BITS-1:0] prio;
        logic [OCC_BITS-1:0]  occ;
    } t_queue_result;

    // Shadow of the sorted row, front first
    logic [PRIO_BITS-1:0] row_prio [DEPTH];
    logic [TAG_BITS-1:0]  row_tag  [DEPTH];
    int                   held;

    t_queue_result awaited_results [$];

    task automatic note_mismatch(input string what);
        o_mismatches++;
        if (o_mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    task automatic apply_item(input logic op, input logic [PRIO_BITS-1:0] prio,
                              input logic [TAG_BITS-1:0] tag);
        t_queue_result r;
        int            pos;
        r.status = spq_pkg::ST_ENQUEUED;
        r.tag    = '0;
        r.prio   = '0;
        if (op == spq_pkg::OP_ENQ) begin
            if (held >= DEPTH) begin
                r.status = spq_pkg::ST_FULL;
            end else begin
                // Insert behind every entry of greater or equal priority
                pos = 0;
                while (pos < held && row_prio[pos] >= prio) pos++;
                for (int i = held; i > pos; i--) begin
                    row_prio[i] = row_prio[i-1];
                    row_tag[i]  = row_tag[i-1];
                end
                row_prio[pos] = prio;
                row_tag[pos]  = tag;
                held++;
            end
        end else begin
            if (held == 0) begin
                r.status = spq_pkg::ST_EMPTY;
            end else begin
                r.status = spq_pkg::ST_SERVED;
                r.prio   = row_prio[0];
                r.tag    = row_tag[0];
                for (int i = 1; i < held; i++) begin
                    row_prio[i-1] = row_prio[i];
                    row_tag[i-1]  = row_tag[i];
                end
                held--;
            end
        end
        r.occ = OCC_BITS'(held);
        awaited_results.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            held = 0;
            awaited_results.delete();
        end else begin
            // Check the departing result before booking the arriving item
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    note_mismatch($sformatf("result with nothing awaited: status %0d tag %h",
                                            i_status, i_served_tag));
                end else begin
                    want = awaited_results.pop_front();
                    if (i_status !== want.status || i_served_tag !== want.tag ||
                        i_served_priority !== want.prio || i_occupancy !== want.occ) begin
                        note_mismatch($sformatf(
                            "expected status %0d tag %h prio %h occ %0d, got %0d %h %h %0d",
                            want.status, want.tag, want.prio, want.occ,
                            i_status, i_served_tag, i_served_priority, i_occupancy));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_item(i_op, i_priority_req, i_tag);
            end
        end
        o_awaited = awaited_results.size();
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH       = 16;
    localparam int PRIO_BITS   = 8;
    localparam int TAG_BITS    = 16;
    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;

    logic                       i_clk          = 1'b0;
    logic                       i_rst_n        = 1'b0;
    logic                       i_in_valid     = 1'b0;
    logic                       i_op           = spq_pkg::OP_ENQ;
    logic [PRIO_BITS-1:0]       i_priority_req = '0;
    logic [TAG_BITS-1:0]        i_tag          = '0;
    logic                       i_out_stall    = 1'b0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [1:0]                 o_status;
    logic [TAG_BITS-1:0]        o_served_tag;
    logic [PRIO_BITS-1:0]       o_served_priority;
    logic [$clog2(DEPTH+1)-1:0] o_occupancy;

    int mismatches;
    int awaited;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;

    always #10 i_clk = ~i_clk;

    stable_priority_queue #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_priority_req    (i_priority_req),
        .i_tag             (i_tag),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_served_tag      (o_served_tag),
        .o_served_priority (o_served_priority),
        .o_occupancy       (o_occupancy)
    );

    spq_checker #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .TAG_BITS  (TAG_BITS)
    ) i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_priority_req    (i_priority_req),
        .i_tag             (i_tag),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_status          (o_status),
        .i_served_tag      (o_served_tag),
        .i_served_priority (o_served_priority),
        .i_occupancy       (o_occupancy),
        .o_mismatches      (mismatches),
        .o_awaited         (awaited)
    );

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [PRIO_BITS-1:0] pick_priority();
        int unsigned r;
        r = $urandom_range(0, 99);
        // Crowd a few values to exercise arrival order among equals
        if (r < 35) return PRIO_BITS'($urandom_range(0, 3));
        if (r < 45) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return PRIO_BITS'($urandom());
    endfunction

    task automatic offer(input logic op, input logic [PRIO_BITS-1:0] prio,
                         input logic [TAG_BITS-1:0] tag);
        int unsigned gap;
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_priority_req <= prio;
        i_tag          <= tag;
        do @(posedge i_clk); while (o_in_stall);
        gap = gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (awaited == 0);
        @(posedge i_clk);
    endtask

    // Receiver: random stall stretches, or one long hold-off on request
    initial begin : receiver
        bit          stall_now;
        int unsigned len;
        forever begin
            if (hold_request) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                stall_now = gaps_on && ($urandom_range(0, 99) < 30);
                len       = stall_now ? idle_len() + 1 : $urandom_range(1, 8);
                i_out_stall <= stall_now;
                repeat (len) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int unsigned enq_pct;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty serve, extremes, ties, fill, drop when full, serve
        offer(spq_pkg::OP_DEQ, '0, '0);
        offer(spq_pkg::OP_ENQ, '0, '0);
        offer(spq_pkg::OP_ENQ, '1, '1);
        offer(spq_pkg::OP_ENQ, 8'd128, 16'h0001);
        offer(spq_pkg::OP_ENQ, 8'd128, 16'h0002);
        offer(spq_pkg::OP_ENQ, 8'd128, 16'h0003);
        offer(spq_pkg::OP_ENQ, '1, 16'h0004);
        offer(spq_pkg::OP_ENQ, '0, 16'h0005);
        offer(spq_pkg::OP_ENQ, 8'd1, 16'h8000);
        offer(spq_pkg::OP_ENQ, 8'd254, 16'h7FFF);
        for (int i = 0; i < DEPTH - 9; i++) begin
            offer(spq_pkg::OP_ENQ, pick_priority(), TAG_BITS'($urandom()));
        end
        offer(spq_pkg::OP_ENQ, 8'd7, 16'hAAAA);
        repeat (5) offer(spq_pkg::OP_DEQ, PRIO_BITS'($urandom()), TAG_BITS'($urandom()));

        // Random segments, each with its own enqueue bias
        for (int seg = 0; seg < 10; seg++) begin
            enq_pct = $urandom_range(10, 90);
            gaps_on = (seg != 3);
            if (seg == 5) begin
                // Back-pressure: hold the output while items keep coming
                hold_request = 1'b1;
                gaps_on      = 1'b0;
            end
            for (int n = 0; n < 100; n++) begin
                offer(($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
                      pick_priority(), TAG_BITS'($urandom()));
            end
            if (seg == 6) drain();
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && awaited == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
